// ===== rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: status codes,
// command kinds and the command that travels from classifier to executor.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int PAGE_BITS   = 12;
   localparam int WORD_BITS   = 32;
   localparam int BIT_IDX_W   = 5;
   localparam int FRAME_NUM_W = 32 - PAGE_BITS;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_NO_FREE       = 3'd1,
      STATUS_MISALIGNED    = 3'd2,
      STATUS_OUT_OF_BOUNDS = 3'd3,
      STATUS_ALREADY_FREE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_ERROR = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                   kind;
      status_type                     status;
      logic [FRAME_NUM_W-1:0]         frame_num;
   } cmd_type;

   // Round an address up to the next page boundary, wrapping modulo 2^32.
   function automatic logic [31:0] round_up_page(input logic [31:0] a);
      logic [31:0] r;
      r = a;
      if (a[PAGE_BITS-1:0] != '0) begin
         r = {a[31:PAGE_BITS] + 1'b1, {PAGE_BITS{1'b0}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/bitmap_frame_allocator_top.sv =====
// A rejected free, or an allocate that finds no free word, gets its result
// straight from the dequeue; an allocate or an in-range free passes through
// dequeue, bitmap read and update. The executor takes no new command until
// it is done with the last, and it waits while the result register is
// blocked. Reset is synchronous; every frame reads free right after reset
// through the fill mark, with no clearing pass, and the frame base is 0.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit page-frame allocator over a usage bitmap, with a classifier,
// a command queue and a read-modify-write executor.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top #(
   parameter int BITMAP_WORDS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,     // kernel_end
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // frame_address
   input  logic [0:0]  req_tuser,     // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata      // status [2:0], allocated_address [34:3], zeros
);
   import bfa_pkg::*;

   logic [31:0] base_ff, base_in;
   logic        q_push;
   cmd_type     q_push_cmd;
   logic        q_full;
   logic        q_pop;
   logic        q_valid;
   cmd_type     q_cmd;

   assign base_in = csr_we ? round_up_page(csr_wdata) : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   bfa_front #(.BITMAP_WORDS(BITMAP_WORDS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .base       (base_ff),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .queue_full (q_full)
   );

   bfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   bfa_back #(.BITMAP_WORDS(BITMAP_WORDS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .base       (base_ff),
      .cmd_valid  (q_valid),
      .cmd        (q_cmd),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_accept_queues: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> q_valid)
      else $error("accepted item did not reach the command queue");

   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_tvalid || rsp_tready))
      else $error("command dequeued while the result register was blocked");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_cmd.kind == CMD_ERROR)) |=> rsp_tvalid)
      else $error("rejected free did not produce a result in the next cycle");
`endif

endmodule

// ===== rtl/bfa_front.sv =====
// ----------------------------------------------------------------------------
// bfa_front
// Request classifier: checks free addresses against alignment and the frame
// range and turns each item into a command for the executor.
// ----------------------------------------------------------------------------
module bfa_front #(
   parameter int BITMAP_WORDS = 128
) (
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [31:0]     req_tdata,   // frame_address
   input  logic [0:0]      req_tuser,   // mode
   input  logic [31:0]     base,
   output logic            push,
   output bfa_pkg::cmd_type push_cmd,
   input  logic            queue_full
);
   import bfa_pkg::*;

   localparam int FRAMES = BITMAP_WORDS * WORD_BITS;

   logic [31:0] offset;
   logic [FRAME_NUM_W-1:0] frame_num;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;
   assign offset     = req_tdata - base;
   assign frame_num  = offset[31:PAGE_BITS];

   always_comb begin
      push_cmd.kind      = CMD_FREE;
      push_cmd.status    = STATUS_OK;
      push_cmd.frame_num = frame_num;
      if (req_tuser[0] == 1'b0) begin
         push_cmd.kind = CMD_ALLOC;
      end else if (req_tdata[PAGE_BITS-1:0] != '0) begin
         push_cmd.kind   = CMD_ERROR;
         push_cmd.status = STATUS_MISALIGNED;
      end else if (req_tdata < base) begin
         push_cmd.kind   = CMD_ERROR;
         push_cmd.status = STATUS_OUT_OF_BOUNDS;
      end else if ({1'b0, frame_num} >= (FRAME_NUM_W+1)'(FRAMES)) begin
         push_cmd.kind   = CMD_ERROR;
         push_cmd.status = STATUS_OUT_OF_BOUNDS;
      end
   end

endmodule

// ===== rtl/bfa_queue.sv =====
// ----------------------------------------------------------------------------
// bfa_queue
// Small command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module bfa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bfa_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output bfa_pkg::cmd_type pop_cmd
);
   import bfa_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/bfa_back.sv =====
// ----------------------------------------------------------------------------
// bfa_back
// Command executor: owns the usage bitmap memory, the word-full summary and
// the result register. Each memory command reads and modifies one bitmap
// word, and writes it back unless a free finds the frame already free.
// ----------------------------------------------------------------------------
module bfa_back #(
   parameter int BITMAP_WORDS = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      base,
   input  logic             cmd_valid,
   input  bfa_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata    // status, allocated_address, zero fill
);
   import bfa_pkg::*;

   localparam int IDX_W  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int FILL_W = $clog2(BITMAP_WORDS + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_READ   = 3'b010,
      S_MODIFY = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   cmd_kind_type         kind_ff, kind_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [WORD_BITS-1:0] mem_ff [BITMAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_written_ff;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [BITMAP_WORDS-1:0] full_ff, full_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;

   logic                 out_free;
   logic                 any_free;
   logic [IDX_W-1:0]     first_free_word;
   logic [WORD_BITS-1:0] word;
   logic [BIT_IDX_W-1:0] first_zero;
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_addr_ff, rsp_status_ff};
   assign cmd_pop    = (state_ff == S_IDLE) && cmd_valid && out_free;

   // Words at or above the fill mark have never been written and read as free.
   assign word    = rd_written_ff ? rd_data_ff : '0;

   always_comb begin
      any_free        = 1'b0;
      first_free_word = '0;
      for (int i = BITMAP_WORDS - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            any_free        = 1'b1;
            first_free_word = IDX_W'(i);
         end
      end
   end

   always_comb begin
      first_zero = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            first_zero = BIT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      bit_in        = bit_ff;
      fill_in       = fill_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      mem_we        = 1'b0;
      mem_wdata     = word;
      case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               kind_in = cmd.kind;
               case (cmd.kind)
                  CMD_ALLOC: begin
                     if (any_free) begin
                        idx_in   = first_free_word;
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NO_FREE;
                        rsp_addr_in   = '0;
                     end
                  end
                  CMD_FREE: begin
                     idx_in   = cmd.frame_num[IDX_W+BIT_IDX_W-1:BIT_IDX_W];
                     bit_in   = cmd.frame_num[BIT_IDX_W-1:0];
                     state_in = S_READ;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = cmd.status;
                     rsp_addr_in   = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               if (kind_ff == CMD_ALLOC) begin
                  mem_we            = 1'b1;
                  mem_wdata         = word | (WORD_BITS'(1) << first_zero);
                  full_in[idx_ff]   = &mem_wdata;
                  rsp_status_in     = STATUS_OK;
                  rsp_addr_in       = base + (32'({idx_ff, first_zero}) << PAGE_BITS);
               end else if (!word[bit_ff]) begin
                  rsp_status_in = STATUS_ALREADY_FREE;
               end else begin
                  mem_we          = 1'b1;
                  mem_wdata       = word & ~(WORD_BITS'(1) << bit_ff);
                  full_in[idx_ff] = 1'b0;
                  rsp_status_in   = STATUS_OK;
               end
               if (mem_we && (FILL_W'(idx_ff) == fill_ff)) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      bit_ff        <= bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // Bitmap memory: one read port used in S_READ, one write port in S_MODIFY.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[idx_ff] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_data_ff    <= mem_ff[idx_ff];
         rd_written_ff <= (FILL_W'(idx_ff) < fill_ff);
      end
   end

endmodule
